// ===== rtl/core/cpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection package
// Shared constants, types and small arithmetic helpers for the projection core.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;
  localparam int SCALE_W       = 14;
  localparam logic [SCALE_W-1:0] WIDTH_SCALE  = SCALE_W'(SCREEN_WIDTH);
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE = SCALE_W'(SCREEN_HEIGHT);
  localparam int SUM_W = 24;
  localparam logic signed [SUM_W-1:0] HALF_WIDTH  = SUM_W'(SCREEN_WIDTH / 2);
  localparam logic signed [SUM_W-1:0] HALF_HEIGHT = SUM_W'(SCREEN_HEIGHT / 2);

  // Fixed point constants of the sine and cosine evaluation.
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] PI_Q29  = 31'd1686629713;

  // Projection offset limit and divider depth.
  localparam int CAP_SHIFT = 20;
  localparam logic [CAP_SHIFT:0] OFFSET_CAP = (CAP_SHIFT + 1)'(1) << CAP_SHIFT;

  // Datapath widths.
  localparam int TRIG_W  = 30;
  localparam int DIFF_W  = 33;
  localparam int COORD_W = 35;
  localparam int MAG_W   = 35;
  localparam int DEPTH_W = 34;
  localparam int ABS_W   = 29;
  localparam int K_W     = 43;
  localparam int K_LO_W  = 22;
  localparam int NUM_W   = 78;
  localparam int DEN_W   = 64;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;
  localparam int FRONT_DEPTH = 5;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    trig_t ys;
    trig_t yc;
    trig_t ps;
    trig_t pc;
    trig_t fxs;
    trig_t fxc;
    trig_t fys;
    trig_t fyc;
  } trig_set_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] z2;
    logic [31:0]               rgba;
  } point_entry_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QUEUE_AW:0] count;
  } queue_status_t;

  typedef enum logic [2:0] {
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_YAW,
    REG_PITCH,
    REG_FOV_X,
    REG_FOV_Y
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_T,
    TS_T2,
    TS_MUL,
    TS_DIV,
    TS_SS,
    TS_DONE
  } trig_state_t;

  // Horner steps: three for sine, then four for cosine.
  localparam logic [2:0] STEP_SIN_LAST = 3'd2;
  localparam logic [2:0] STEP_COS_LAST = 3'd6;

  // Floor of x divided by the Horner divisor of a step (42, 20, 6, 56, 30,
  // 12, then 2). Each divisor splits into a shift and an odd factor, and the
  // odd factor is divided by a rounded-up reciprocal, which is exact for every
  // dividend below 2^30.
  function automatic logic [29:0] horner_quotient(input logic [29:0] x,
                                                  input logic [2:0]  step);
    logic [1:0]  sh;
    logic [30:0] recip;
    logic [5:0]  rs;
    logic [29:0] y;
    logic [60:0] prod;
    unique case (step)
      3'd0: begin
        sh = 2'd1; recip = 31'd1636178018; rs = 6'd35;
      end
      3'd1: begin
        sh = 2'd2; recip = 31'd1717986919; rs = 6'd33;
      end
      3'd2: begin
        sh = 2'd1; recip = 31'd1431655766; rs = 6'd32;
      end
      3'd3: begin
        sh = 2'd3; recip = 31'd1227133514; rs = 6'd33;
      end
      3'd4: begin
        sh = 2'd1; recip = 31'd1145324613; rs = 6'd34;
      end
      3'd5: begin
        sh = 2'd2; recip = 31'd1431655766; rs = 6'd32;
      end
      default: begin
        sh = 2'd1; recip = 31'd1; rs = 6'd0;
      end
    endcase
    y    = x >> sh;
    prod = 61'(y) * 61'(recip);
    return 30'(prod >> rs);
  endfunction

  // Round a Q28 product sum half up to Q16.16.
  function automatic logic signed [COORD_W-1:0] round_q28(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v + 66'sd134217728;
    return r[62:28];
  endfunction

  function automatic logic [ABS_W-1:0] abs_trig(input trig_t v);
    return v[TRIG_W-1] ? ABS_W'(-v) : ABS_W'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/camera_point_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection
// Projects world points through a yaw and pitch camera onto the screen.
// ----------------------------------------------------------------------------
// The block takes one point request per clock whenever busy is low and marks
// each result with out_valid for a single cycle; there is no way to hold
// results off, so the consumer must take every strobe. Points whose rotated
// depth is not positive are dropped and give no strobe. A point passes through
// the rotation pipeline (five stages), the queue and the back end with its
// twenty-step pipelined divider. After reset and after every configuration
// write, busy stays high while a shared sequencer recomputes the sine and
// cosine of yaw, pitch and both fields of view; configure only while no points
// are in flight.
module camera_point_projection (
  input  logic               clk,
  input  logic               rst,
  // Point requests.
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [31:0]        rgba,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // Results.
  output logic               out_valid,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic [31:0]        out_rgba
);
  import cpp_pkg::*;

  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [15:0]        yaw, pitch;
  logic [14:0]        fov_x, fov_y;
  logic               cfg_write;
  logic               accept;
  logic               trig_running;
  trig_set_t          trig;
  logic               q_push;
  point_entry_t       q_wr, q_rd;
  queue_status_t      q_status;

  // Writes are always taken; each one restarts the trig sequencer.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      yaw   <= '0;
      pitch <= '0;
      fov_x <= 15'd8447;
      fov_y <= 15'd5152;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CAM_X: cam_x <= cfg_data;
        REG_CAM_Y: cam_y <= cfg_data;
        REG_CAM_Z: cam_z <= cfg_data;
        REG_YAW:   yaw   <= cfg_data[15:0];
        REG_PITCH: pitch <= cfg_data[15:0];
        REG_FOV_X: fov_x <= cfg_data[14:0];
        REG_FOV_Y: fov_y <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // The back end drains the queue every cycle, so the level check is a guard
  // that keeps room for everything the front end may still push.
  assign busy   = trig_running ||
                  (q_status.count > (QUEUE_AW + 1)'(QUEUE_DEPTH - FRONT_DEPTH - 1));
  assign accept = start && !busy;

  cpp_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .yaw     (yaw),
    .pitch   (pitch),
    .fov_x   (fov_x),
    .fov_y   (fov_y),
    .trig    (trig),
    .running (trig_running)
  );

  cpp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .rgba    (rgba),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .trig    (trig),
    .push    (q_push),
    .entry   (q_wr)
  );

  cpp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (!q_status.empty),
    .rd_entry (q_rd),
    .status   (q_status)
  );

  cpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_status.empty),
    .in_entry  (q_rd),
    .trig      (trig),
    .out_valid (out_valid),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .out_rgba  (out_rgba)
  );

  // The queue must never be asked to take a point it has no room for.
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_status.full))
    else $error("queue overflow");

  // A configuration write must hold off point requests while trig recomputes.
  assert property (@(posedge clk) disable iff (rst) cfg_write |=> busy)
    else $error("not busy after configuration write");

  // With the back end draining every cycle the queue holds at most one entry.
  assert property (@(posedge clk) disable iff (rst)
                   q_status.count <= (QUEUE_AW + 1)'(1))
    else $error("queue backing up");

endmodule

// ===== rtl/core/cpp_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection trig sequencer
// Evaluates sine and cosine of yaw, pitch and both fields of view in turn.
// ----------------------------------------------------------------------------
module cpp_trig (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [15:0]       yaw,
  input  logic [15:0]       pitch,
  input  logic [14:0]       fov_x,
  input  logic [14:0]       fov_y,
  output cpp_pkg::trig_set_t trig,
  output logic              running
);
  import cpp_pkg::*;

  trig_state_t state, state_next;
  logic [1:0]  ang_idx;
  logic [2:0]  step;
  logic [1:0]  quad;
  logic        swap;
  logic [29:0] t, t2, dividend, quo;
  logic [30:0] p, ss;
  logic [15:0] ang;
  logic [13:0] u;
  logic        swap_nx;
  logic [44:0] t_prod;
  logic [30:0] mul_b;
  logic [29:0] mul_a;
  logic [60:0] mul_prod;
  logic [29:0] mul_hi;
  logic [30:0] ss_f, cc_f;
  logic [28:0] si, co;
  trig_t       s_pos, c_pos, s_out, c_out;

  always_comb begin
    unique case (ang_idx)
      2'd0:    ang = yaw;
      2'd1:    ang = pitch;
      2'd2:    ang = {1'b0, fov_x};
      default: ang = {1'b0, fov_y};
    endcase
  end

  // Octant reduction.
  assign swap_nx = ang[13:0] > 14'd8192;
  assign u       = swap_nx ? 14'(15'd16384 - {1'b0, ang[13:0]}) : ang[13:0];
  assign t_prod  = 45'(u) * 45'(PI_Q29);

  // One shared multiplier serves t*t, t2*p and t*p.
  assign mul_a    = (state == TS_T2 || state == TS_SS) ? t : t2;
  assign mul_b    = (state == TS_T2) ? {1'b0, t} : p;
  assign mul_prod = 61'(mul_a) * 61'(mul_b);
  assign mul_hi   = mul_prod[59:30];

  // Division by the small constant of the current step, done combinationally.
  assign quo = horner_quotient(dividend, step);

  // Final symmetry step: p holds the cosine series at this point.
  assign ss_f  = swap ? p : ss;
  assign cc_f  = swap ? ss : p;
  assign si    = 29'((ss_f + 31'd2) >> 2);
  assign co    = 29'((cc_f + 31'd2) >> 2);
  assign s_pos = trig_t'({1'b0, si});
  assign c_pos = trig_t'({1'b0, co});

  always_comb begin
    unique case (quad)
      2'd0: begin
        s_out = s_pos;
        c_out = c_pos;
      end
      2'd1: begin
        s_out = c_pos;
        c_out = -s_pos;
      end
      2'd2: begin
        s_out = -s_pos;
        c_out = -c_pos;
      end
      default: begin
        s_out = -c_pos;
        c_out = s_pos;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TS_IDLE: state_next = TS_IDLE;
      TS_T:    state_next = TS_T2;
      TS_T2:   state_next = TS_DIV;
      TS_MUL:  state_next = TS_DIV;
      TS_DIV: begin
        if (step == STEP_SIN_LAST) begin
          state_next = TS_SS;
        end else if (step == STEP_COS_LAST) begin
          state_next = TS_DONE;
        end else begin
          state_next = TS_MUL;
        end
      end
      TS_SS:   state_next = TS_DIV;
      TS_DONE: state_next = (ang_idx == 2'd3) ? TS_IDLE : TS_T;
      default: state_next = TS_IDLE;
    endcase
    if (restart) begin
      state_next = TS_T;
    end
  end

  assign running = state != TS_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= TS_T;
      ang_idx <= 2'd0;
    end else begin
      state <= state_next;
      if (restart) begin
        ang_idx <= 2'd0;
      end else if (state == TS_DONE) begin
        ang_idx <= ang_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      TS_T: begin
        quad <= ang[15:14];
        swap <= swap_nx;
        t    <= t_prod[43:14];
      end
      TS_T2: begin
        t2       <= mul_hi;
        dividend <= mul_hi;
        step     <= '0;
      end
      TS_MUL: begin
        dividend <= mul_hi;
      end
      TS_DIV: begin
        p <= Q30_ONE - 31'(quo);
        if (step != STEP_COS_LAST) begin
          step <= step + 3'd1;
        end
      end
      TS_SS: begin
        ss       <= {1'b0, mul_hi};
        dividend <= t2;
      end
      TS_DONE: begin
        unique case (ang_idx)
          2'd0: begin
            trig.ys <= s_out;
            trig.yc <= c_out;
          end
          2'd1: begin
            trig.ps <= s_out;
            trig.pc <= c_out;
          end
          2'd2: begin
            trig.fxs <= s_out;
            trig.fxc <= c_out;
          end
          default: begin
            trig.fys <= s_out;
            trig.fyc <= c_out;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/cpp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection front end
// Translates and rotates accepted points and drops those behind the camera.
// ----------------------------------------------------------------------------
module cpp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic signed [31:0]    point_z,
  input  logic [31:0]           rgba,
  input  logic signed [31:0]    cam_x,
  input  logic signed [31:0]    cam_y,
  input  logic signed [31:0]    cam_z,
  input  cpp_pkg::trig_set_t    trig,
  output logic                  push,
  output cpp_pkg::point_entry_t entry
);
  import cpp_pkg::*;

  logic v0, v1, v2, v3;
  logic signed [DIFF_W-1:0]  rx, ry0, rz, ry1, ry2;
  logic [31:0]               rgba0, rgba1, rgba2, rgba3;
  logic signed [62:0]        m_xc, m_zs, m_zc, m_xs;
  logic signed [COORD_W-1:0] x1, z1, x1_3, y2, z2;
  logic signed [64:0]        m_yp, m_zps, m_zpc, m_yps;

  assign y2 = round_q28(66'(m_yp) - 66'(m_zps));
  assign z2 = round_q28(66'(m_zpc) + 66'(m_yps));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      push <= 1'b0;
    end else begin
      v0   <= accept;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      push <= v3 && (z2 > 35'sd0);
    end
  end

  always_ff @(posedge clk) begin
    // Camera-relative position.
    rx    <= DIFF_W'(point_x) - DIFF_W'(cam_x);
    ry0   <= DIFF_W'(point_y) - DIFF_W'(cam_y);
    rz    <= DIFF_W'(point_z) - DIFF_W'(cam_z);
    rgba0 <= rgba;
    // Yaw products.
    m_xc  <= 63'(rx) * 63'($signed(trig.yc));
    m_zs  <= 63'(rz) * 63'($signed(trig.ys));
    m_zc  <= 63'(rz) * 63'($signed(trig.yc));
    m_xs  <= 63'(rx) * 63'($signed(trig.ys));
    ry1   <= ry0;
    rgba1 <= rgba0;
    // Yaw sums.
    x1    <= round_q28(66'(m_xc) + 66'(m_zs));
    z1    <= round_q28(66'(m_zc) - 66'(m_xs));
    ry2   <= ry1;
    rgba2 <= rgba1;
    // Pitch products.
    m_yp  <= 65'(ry2) * 65'($signed(trig.pc));
    m_zps <= 65'(z1) * 65'($signed(trig.ps));
    m_zpc <= 65'(z1) * 65'($signed(trig.pc));
    m_yps <= 65'(ry2) * 65'($signed(trig.ps));
    x1_3  <= x1;
    rgba3 <= rgba2;
    // Pitch sums go straight to the queue.
    entry.x1   <= x1_3;
    entry.y2   <= y2;
    entry.z2   <= z2;
    entry.rgba <= rgba3;
  end

endmodule

// ===== rtl/core/cpp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection queue
// Short FIFO that decouples the rotation front end from the projection back end.
// ----------------------------------------------------------------------------
module cpp_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cpp_pkg::point_entry_t  wr_entry,
  input  logic                   pop,
  output cpp_pkg::point_entry_t  rd_entry,
  output cpp_pkg::queue_status_t status
);
  import cpp_pkg::*;

  point_entry_t        mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push, do_pop;

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  assign status.empty = count == '0;
  assign status.full  = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign status.count = count;
  assign rd_entry     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ===== rtl/core/cpp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection back end
// Perspective divide, rounding and saturation to screen coordinates.
// ----------------------------------------------------------------------------
module cpp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cpp_pkg::point_entry_t in_entry,
  input  cpp_pkg::trig_set_t    trig,
  output logic                  out_valid,
  output logic signed [15:0]    screen_x,
  output logic signed [15:0]    screen_y,
  output logic [31:0]           out_rgba
);
  import cpp_pkg::*;

  localparam int DIV_STEPS = CAP_SHIFT;

  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [DIV_STEPS-1:0] lo;
    logic [DIV_STEPS-1:0] q;
    logic                 sat;
    logic                 dz;
    logic                 nz;
    logic                 neg;
  } div_lane_t;

  function automatic div_lane_t div_step(input div_lane_t a);
    div_lane_t        r;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    r      = a;
    rem_sh = {a.rem, a.lo[DIV_STEPS-1]};
    ge     = rem_sh >= {1'b0, a.den};
    r.rem  = ge ? DEN_W'(rem_sh - {1'b0, a.den}) : rem_sh[DEN_W-1:0];
    r.lo   = a.lo << 1;
    r.q    = {a.q[DIV_STEPS-2:0], ge};
    return r;
  endfunction

  // Scale factors that follow the field of view; lane 0 is x, lane 1 is y.
  logic [K_W-1:0]   k    [2];
  logic [ABS_W-1:0] asn  [2];

  // Stage registers.
  logic                 v0, v1, v2;
  logic [MAG_W-1:0]     mag0 [2];
  logic                 neg0 [2], neg1 [2], neg2 [2];
  logic [DEPTH_W-1:0]   depth0;
  logic [31:0]          rgba0, rgba1, rgba2;
  logic [56:0]          plo1 [2];
  logic [55:0]          phi1 [2];
  logic [DEN_W-1:0]     den1 [2], den2 [2];
  logic [NUM_W-1:0]     num2 [2];
  div_lane_t            div_pipe [DIV_STEPS+1][2];
  logic                 div_v [DIV_STEPS+1];
  logic [31:0]          div_rgba [DIV_STEPS+1];

  logic [CAP_SHIFT:0]        mag_q [2];
  logic signed [SUM_W-1:0]   off [2];

  always_ff @(posedge clk) begin
    k[0]   <= K_W'(WIDTH_SCALE) * K_W'(abs_trig(trig.fxc));
    k[1]   <= K_W'(HEIGHT_SCALE) * K_W'(abs_trig(trig.fyc));
    asn[0] <= abs_trig(trig.fxs);
    asn[1] <= abs_trig(trig.fys);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) begin
        div_v[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      v0       <= in_valid;
      v1       <= v0;
      v2       <= v1;
      div_v[0] <= v2;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_v[i+1] <= div_v[i];
      end
      out_valid <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    // Magnitudes and signs.
    mag0[0] <= in_entry.x1[COORD_W-1] ? MAG_W'(-in_entry.x1) : MAG_W'(in_entry.x1);
    mag0[1] <= in_entry.y2[COORD_W-1] ? MAG_W'(-in_entry.y2) : MAG_W'(in_entry.y2);
    neg0[0] <= in_entry.x1[COORD_W-1] ^ trig.fxc[TRIG_W-1] ^ trig.fxs[TRIG_W-1];
    neg0[1] <= in_entry.y2[COORD_W-1] ^ trig.fyc[TRIG_W-1] ^ trig.fys[TRIG_W-1];
    depth0  <= in_entry.z2[DEPTH_W-1:0];
    rgba0   <= in_entry.rgba;
    for (int l = 0; l < 2; l++) begin
      // Numerator in two partial products, denominator in one.
      plo1[l] <= 57'(mag0[l]) * 57'(k[l][K_LO_W-1:0]);
      phi1[l] <= 56'(mag0[l]) * 56'(k[l][K_W-1:K_LO_W]);
      den1[l] <= DEN_W'(depth0) * DEN_W'(asn[l]);
      neg1[l] <= neg0[l];
      num2[l] <= NUM_W'(plo1[l]) + (NUM_W'(phi1[l]) << K_LO_W);
      den2[l] <= den1[l];
      neg2[l] <= neg1[l];
      // Divider setup: a quotient at or above the cap is flagged up front.
      div_pipe[0][l].sat <= {6'b0, num2[l]} >= {den2[l], CAP_SHIFT'(0)};
      div_pipe[0][l].dz  <= den2[l] == '0;
      div_pipe[0][l].nz  <= num2[l] != '0;
      div_pipe[0][l].neg <= neg2[l];
      div_pipe[0][l].rem <= DEN_W'(num2[l][NUM_W-1:CAP_SHIFT]);
      div_pipe[0][l].den <= den2[l];
      div_pipe[0][l].lo  <= num2[l][CAP_SHIFT-1:0];
      div_pipe[0][l].q   <= '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_pipe[i+1][l] <= div_step(div_pipe[i][l]);
      end
    end
    rgba1       <= rgba0;
    rgba2       <= rgba1;
    div_rgba[0] <= rgba2;
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_rgba[i+1] <= div_rgba[i];
    end
    screen_x <= sat16(HALF_WIDTH + off[0]);
    screen_y <= sat16(HALF_HEIGHT - off[1]);
    out_rgba <= div_rgba[DIV_STEPS];
  end

  // Rounding, capping and sign.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      priority if (div_pipe[DIV_STEPS][l].dz) begin
        mag_q[l] = div_pipe[DIV_STEPS][l].nz ? OFFSET_CAP : '0;
      end else if (div_pipe[DIV_STEPS][l].sat) begin
        mag_q[l] = OFFSET_CAP;
      end else begin
        mag_q[l] = (CAP_SHIFT + 1)'(div_pipe[DIV_STEPS][l].q)
                 + (CAP_SHIFT + 1)'(div_pipe[DIV_STEPS][l].rem >=
                     div_pipe[DIV_STEPS][l].den - div_pipe[DIV_STEPS][l].rem);
      end
      off[l] = div_pipe[DIV_STEPS][l].neg ? -SUM_W'(mag_q[l]) : SUM_W'(mag_q[l]);
    end
  end

endmodule
